// ===== rtl/ilp_pkg.sv =====
// shared types, constants and saturating helpers for the intercept lead point solver
// no dependencies; imported by every rtl file of the block
package ilp_pkg;

  localparam int WORD_W  = 32;
  localparam int SPEED_W = 31;
  localparam int STEP_W  = 5;
  localparam int TOL_W   = 16;
  localparam int AXES    = 3;
  localparam int IN_W    = 320;
  localparam int OUT_W   = 104;
  localparam int USER_W  = 2;
  localparam int CNT_OUT_W = 3;

  // configuration register indexes
  localparam logic REG_SETTLE_TOL = 1'b0;
  localparam logic REG_MIN_SPEED  = 1'b1;

  localparam logic [TOL_W-1:0] SETTLE_TOL_RST = TOL_W'(66);
  localparam logic [TOL_W-1:0] MIN_SPEED_RST  = TOL_W'(66);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [AXES-1:0][WORD_W-1:0] vec3_t;

  // everything one item carries from iteration to iteration
  typedef struct packed {
    vec3_t               shooter;
    vec3_t               tpos;
    vec3_t               tvel;
    vec3_t               aim;
    vec3_t               lead;
    logic [SPEED_W-1:0]  speed;
    logic [STEP_W-1:0]   steps;
    logic                too_slow;
    logic                clip;
    logic                done;
  } ctx_t;

  typedef struct packed {
    logic  clip;
    word_t val;
  } sat_t;

  function automatic sat_t sat33(input logic [WORD_W:0] s);
    sat_t r;
    r.clip = s[WORD_W] ^ s[WORD_W-1];
    if (r.clip) begin
      r.val = s[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    end else begin
      r.val = s[WORD_W-1:0];
    end
    return r;
  endfunction

  function automatic sat_t sub_sat(input word_t a, input word_t b);
    return sat33({a[WORD_W-1], a} - {b[WORD_W-1], b});
  endfunction

  function automatic sat_t add_sat(input word_t a, input word_t b);
    return sat33({a[WORD_W-1], a} + {b[WORD_W-1], b});
  endfunction

  // magnitude of a signed word; the most negative value maps to 2^31 unsigned
  function automatic word_t mag(input word_t v);
    return v[WORD_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

// ===== rtl/ilp_sqrt.sv =====
// pipelined integer square root, one root bit per register stage, with side payload
// depends on ilp_pkg
module ilp_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_vld,
  input  logic [2*ilp_pkg::WORD_W-1:0]   in_rad,
  input  logic [SIDE_W-1:0]              in_side,
  output logic                           out_vld,
  output logic [ilp_pkg::WORD_W-1:0]     out_root,
  output logic [SIDE_W-1:0]              out_side
);
  import ilp_pkg::*;

  localparam int ROOT_W = WORD_W;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 3;

  logic              vld_r  [ROOT_W];
  logic [RAD_W-1:0]  rad_r  [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [SIDE_W-1:0] side_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              vld_i;
    logic [RAD_W-1:0]  rad_i;
    logic [REM_W-1:0]  rem_i;
    logic [ROOT_W-1:0] root_i;
    logic [SIDE_W-1:0] side_i;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (k == 0) begin : g_first
      always_comb begin
        vld_i  = in_vld;
        rad_i  = in_rad;
        rem_i  = '0;
        root_i = '0;
        side_i = in_side;
      end
    end else begin : g_next
      always_comb begin
        vld_i  = vld_r[k-1];
        rad_i  = rad_r[k-1];
        rem_i  = rem_r[k-1];
        root_i = root_r[k-1];
        side_i = side_r[k-1];
      end
    end

    always_comb begin
      rem_sh = {rem_i[REM_W-3:0], rad_i[RAD_W-1:RAD_W-2]};
      trial  = REM_W'({root_i, 2'b01});
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_i[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_i[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k]  <= vld_i;
        rad_r[k]  <= {rad_i[RAD_W-3:0], 2'b00};
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        side_r[k] <= side_i;
      end
    end
  end

  assign out_vld  = vld_r[ROOT_W-1];
  assign out_root = root_r[ROOT_W-1];
  assign out_side = side_r[ROOT_W-1];

endmodule

// ===== rtl/ilp_iter.sv =====
// one solver iteration as a pipeline: distance, time of flight, new lead point, settle test
// depends on ilp_pkg and ilp_sqrt
module ilp_iter #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  ilp_pkg::ctx_t               in_ctx,
  input  logic [ilp_pkg::TOL_W-1:0]   tol,
  output logic                        out_vld,
  output ilp_pkg::ctx_t               out_ctx
);
  import ilp_pkg::*;

  localparam int NUM_W  = SPEED_W + FRACTION_BITS;
  localparam int QB     = SPEED_W;
  localparam int PROD_W = 2 * WORD_W;
  localparam int SQ_W   = 2 * WORD_W;
  localparam word_t S32_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t S32_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  // distance from shooter to current aim point
  logic               a_vld_r;
  ctx_t               a_ctx_r, a_ctx_nxt;
  word_t              a_mag_r [AXES];
  word_t              a_mag_nxt [AXES];

  always_comb begin
    logic any_clip;
    sat_t d;
    any_clip  = 1'b0;
    a_ctx_nxt = in_ctx;
    for (int i = 0; i < AXES; i++) begin
      d = sub_sat(in_ctx.shooter[i], in_ctx.aim[i]);
      any_clip = any_clip | d.clip;
      a_mag_nxt[i] = mag(d.val);
    end
    a_ctx_nxt.clip = in_ctx.clip | (any_clip & ~in_ctx.done);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_vld;
      a_ctx_r <= a_ctx_nxt;
      for (int i = 0; i < AXES; i++) a_mag_r[i] <= a_mag_nxt[i];
    end
  end

  logic            b_vld_r;
  ctx_t            b_ctx_r;
  logic [SQ_W-1:0] b_sq_r [AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
      b_ctx_r <= a_ctx_r;
      for (int i = 0; i < AXES; i++) b_sq_r[i] <= a_mag_r[i] * a_mag_r[i];
    end
  end

  logic            c_vld_r;
  ctx_t            c_ctx_r;
  logic [SQ_W-1:0] c_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= b_vld_r;
      c_ctx_r <= b_ctx_r;
      c_sum_r <= b_sq_r[0] + b_sq_r[1] + b_sq_r[2];
    end
  end

  logic  s1_vld;
  word_t s1_root;
  ctx_t  s1_ctx;

  ilp_sqrt #(.SIDE_W($bits(ctx_t))) u_sqrt_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (c_vld_r),
    .in_rad   (c_sum_r),
    .in_side  (c_ctx_r),
    .out_vld  (s1_vld),
    .out_root (s1_root),
    .out_side (s1_ctx)
  );

  // divider setup: overflow check and first partial remainder
  logic                d_vld_r;
  ctx_t                d_ctx_r, d_ctx_nxt;
  word_t               d_rem_r, d_rem_nxt;
  logic [SPEED_W-1:0]  d_num_r;
  logic                d_ovf_r, d_ovf_nxt;
  logic [SPEED_W-1:0]  dist_sat;
  logic                dist_clip;
  logic [NUM_W-1:0]    numer;
  word_t               numer_hi;

  always_comb begin
    dist_clip = s1_root[WORD_W-1];
    dist_sat  = dist_clip ? {SPEED_W{1'b1}} : s1_root[SPEED_W-1:0];
    numer     = {dist_sat, {FRACTION_BITS{1'b0}}};
    numer_hi  = WORD_W'(numer[NUM_W-1:SPEED_W]);
    d_ovf_nxt = numer_hi >= WORD_W'(s1_ctx.speed);
    d_rem_nxt = d_ovf_nxt ? '0 : numer_hi;
    d_ctx_nxt = s1_ctx;
    d_ctx_nxt.clip = s1_ctx.clip | (dist_clip & ~s1_ctx.done);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= s1_vld;
      d_ctx_r <= d_ctx_nxt;
      d_rem_r <= d_rem_nxt;
      d_num_r <= numer[SPEED_W-1:0];
      d_ovf_r <= d_ovf_nxt;
    end
  end

  // restoring divider, one quotient bit per stage
  logic               q_vld_r [QB];
  ctx_t               q_ctx_r [QB];
  word_t              q_rem_r [QB];
  logic [SPEED_W-1:0] q_num_r [QB];
  logic [QB-1:0]      q_quo_r [QB];
  logic               q_ovf_r [QB];

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic               vld_i;
    ctx_t               ctx_i;
    word_t              rem_i;
    logic [SPEED_W-1:0] num_i;
    logic [QB-1:0]      quo_i;
    logic               ovf_i;
    word_t              rem_sh;
    word_t              rem_nxt;
    logic               ge;

    if (k == 0) begin : g_first
      always_comb begin
        vld_i = d_vld_r;
        ctx_i = d_ctx_r;
        rem_i = d_rem_r;
        num_i = d_num_r;
        quo_i = '0;
        ovf_i = d_ovf_r;
      end
    end else begin : g_next
      always_comb begin
        vld_i = q_vld_r[k-1];
        ctx_i = q_ctx_r[k-1];
        rem_i = q_rem_r[k-1];
        num_i = q_num_r[k-1];
        quo_i = q_quo_r[k-1];
        ovf_i = q_ovf_r[k-1];
      end
    end

    always_comb begin
      rem_sh  = {rem_i[WORD_W-2:0], num_i[SPEED_W-1]};
      ge      = rem_sh >= WORD_W'(ctx_i.speed);
      rem_nxt = ge ? rem_sh - WORD_W'(ctx_i.speed) : rem_sh;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        q_vld_r[k] <= 1'b0;
      end else if (en) begin
        q_vld_r[k] <= vld_i;
        q_ctx_r[k] <= ctx_i;
        q_rem_r[k] <= rem_nxt;
        q_num_r[k] <= {num_i[SPEED_W-2:0], 1'b0};
        q_quo_r[k] <= {quo_i[QB-2:0], ge};
        q_ovf_r[k] <= ovf_i;
      end
    end
  end

  // velocity times time of flight
  logic                     m_vld_r;
  ctx_t                     m_ctx_r, m_ctx_nxt;
  logic signed [PROD_W-1:0] m_prod_r [AXES];
  logic [QB-1:0]            tof;

  always_comb begin
    tof = q_ovf_r[QB-1] ? {QB{1'b1}} : q_quo_r[QB-1];
    m_ctx_nxt = q_ctx_r[QB-1];
    m_ctx_nxt.clip = q_ctx_r[QB-1].clip | (q_ovf_r[QB-1] & ~q_ctx_r[QB-1].done);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= q_vld_r[QB-1];
      m_ctx_r <= m_ctx_nxt;
      for (int i = 0; i < AXES; i++) begin
        m_prod_r[i] <= $signed(m_ctx_nxt.tvel[i]) * $signed({1'b0, tof});
      end
    end
  end

  // scale, saturate and add to the target position
  logic p_vld_r;
  ctx_t p_ctx_r, p_ctx_nxt;

  always_comb begin
    logic signed [PROD_W-1:0] sh;
    logic                     any_clip;
    logic                     off_clip;
    word_t                    off;
    sat_t                     s;
    any_clip  = 1'b0;
    p_ctx_nxt = m_ctx_r;
    for (int i = 0; i < AXES; i++) begin
      sh = m_prod_r[i] >>> FRACTION_BITS;
      off_clip = !((&sh[PROD_W-1:WORD_W-1]) || !(|sh[PROD_W-1:WORD_W-1]));
      off = off_clip ? (sh[PROD_W-1] ? S32_MIN : S32_MAX) : sh[WORD_W-1:0];
      s = add_sat(m_ctx_r.tpos[i], off);
      any_clip = any_clip | off_clip | s.clip;
      p_ctx_nxt.lead[i] = s.val;
    end
    p_ctx_nxt.clip = m_ctx_r.clip | (any_clip & ~m_ctx_r.done);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (en) begin
      p_vld_r <= m_vld_r;
      p_ctx_r <= p_ctx_nxt;
    end
  end

  // movement of the aim point; saturation here is not reported
  logic  e_vld_r;
  ctx_t  e_ctx_r;
  word_t e_mag_r [AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (en) begin
      e_vld_r <= p_vld_r;
      e_ctx_r <= p_ctx_r;
      for (int i = 0; i < AXES; i++) begin
        e_mag_r[i] <= mag(sub_sat(p_ctx_r.lead[i], p_ctx_r.aim[i]).val);
      end
    end
  end

  logic            f_vld_r;
  ctx_t            f_ctx_r;
  logic [SQ_W-1:0] f_sq_r [AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= e_vld_r;
      f_ctx_r <= e_ctx_r;
      for (int i = 0; i < AXES; i++) f_sq_r[i] <= e_mag_r[i] * e_mag_r[i];
    end
  end

  logic            g_vld_r;
  ctx_t            g_ctx_r;
  logic [SQ_W-1:0] g_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else if (en) begin
      g_vld_r <= f_vld_r;
      g_ctx_r <= f_ctx_r;
      g_sum_r <= f_sq_r[0] + f_sq_r[1] + f_sq_r[2];
    end
  end

  logic  s2_vld;
  word_t s2_root;
  ctx_t  s2_ctx;

  ilp_sqrt #(.SIDE_W($bits(ctx_t))) u_sqrt_move (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (g_vld_r),
    .in_rad   (g_sum_r),
    .in_side  (g_ctx_r),
    .out_vld  (s2_vld),
    .out_root (s2_root),
    .out_side (s2_ctx)
  );

  // commit the new aim point unless the item had already settled
  logic h_vld_r;
  ctx_t h_ctx_r, h_ctx_nxt;

  always_comb begin
    h_ctx_nxt = s2_ctx;
    if (!s2_ctx.done) begin
      h_ctx_nxt.aim   = s2_ctx.lead;
      h_ctx_nxt.steps = s2_ctx.steps + 1'b1;
      h_ctx_nxt.done  = s2_root < WORD_W'(tol);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= 1'b0;
    end else if (en) begin
      h_vld_r <= s2_vld;
      h_ctx_r <= h_ctx_nxt;
    end
  end

  assign out_vld = h_vld_r;
  assign out_ctx = h_ctx_r;

endmodule

// ===== rtl/intercept_lead_point_top.sv =====
// top level of the intercept lead point solver: stream ports, config registers, iteration chain
// depends on ilp_pkg and ilp_iter
//
// usage:
//   in_*  : one aim request per transfer (shooter, target, velocity, projectile speed)
//   out_* : one lead point per request, in request order
//   cfg_* : settle tolerance (index 0) and minimum speed (index 1), written while idle
// pipeline: each iteration is two 32-stage square roots, a 31-stage divider and the
//   arithmetic stages around them, all fully pipelined
// throughput: one request per cycle while out_tready is high
// the iteration count is fixed in hardware; a request that settles early
//   passes the remaining iterations unchanged
// reset: all valid bits clear, tolerance and minimum speed return to 66
// stall: when out_tvalid is high and out_tready low the whole pipeline holds,
//   in_tready drops, and nothing is lost or repeated
module intercept_lead_point_top #(
  parameter int MAX_STEPS     = 6,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // shooter_x, shooter_y, shooter_z, target_x, target_y, target_z,
  // target_vel_x, target_vel_y, target_vel_z, projectile_speed, zero fill
  input  logic [ilp_pkg::IN_W-1:0]      in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // aim_x, aim_y, aim_z, steps_used, zero fill
  output logic [ilp_pkg::OUT_W-1:0]     out_tdata,
  // too_slow, clipped
  output logic [ilp_pkg::USER_W-1:0]    out_tuser,
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [ilp_pkg::TOL_W-1:0]     cfg_wdata
);
  import ilp_pkg::*;

  localparam int VEC_W = AXES * WORD_W;

  logic               en;
  logic [TOL_W-1:0]   tol_r;
  logic [TOL_W-1:0]   min_speed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r       <= SETTLE_TOL_RST;
      min_speed_r <= MIN_SPEED_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SETTLE_TOL: tol_r       <= cfg_wdata;
        REG_MIN_SPEED:  min_speed_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // whole pipeline advances together whenever the output slot can move
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic               e_vld_r;
  ctx_t               e_ctx_r, e_ctx_nxt;
  logic [SPEED_W-1:0] speed;
  logic               slow;

  always_comb begin
    speed = in_tdata[3*VEC_W +: SPEED_W];
    slow  = (speed == '0) || (speed < SPEED_W'(min_speed_r));
    e_ctx_nxt.shooter  = in_tdata[0 +: VEC_W];
    e_ctx_nxt.tpos     = in_tdata[VEC_W +: VEC_W];
    e_ctx_nxt.tvel     = in_tdata[2*VEC_W +: VEC_W];
    e_ctx_nxt.aim      = in_tdata[VEC_W +: VEC_W];
    e_ctx_nxt.lead     = in_tdata[VEC_W +: VEC_W];
    e_ctx_nxt.speed    = speed;
    e_ctx_nxt.steps    = '0;
    e_ctx_nxt.too_slow = slow;
    e_ctx_nxt.clip     = 1'b0;
    e_ctx_nxt.done     = slow;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (en) begin
      e_vld_r <= in_tvalid;
      e_ctx_r <= e_ctx_nxt;
    end
  end

  logic chain_vld [MAX_STEPS+1];
  ctx_t chain_ctx [MAX_STEPS+1];

  assign chain_vld[0] = e_vld_r;
  assign chain_ctx[0] = e_ctx_r;

  for (genvar s = 0; s < MAX_STEPS; s++) begin : g_iter
    ilp_iter #(.FRACTION_BITS(FRACTION_BITS)) u_iter (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (chain_vld[s]),
      .in_ctx  (chain_ctx[s]),
      .tol     (tol_r),
      .out_vld (chain_vld[s+1]),
      .out_ctx (chain_ctx[s+1])
    );
  end

  logic              out_vld_r;
  logic [OUT_W-1:0]  out_data_r;
  logic [USER_W-1:0] out_user_r;
  ctx_t              fin;

  assign fin = chain_ctx[MAX_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r  <= chain_vld[MAX_STEPS];
      out_data_r <= OUT_W'({fin.steps[CNT_OUT_W-1:0], fin.aim});
      out_user_r <= {fin.clip, fin.too_slow};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== rtl/ilp_chk.sv =====
// port-level checker for intercept_lead_point_top, bound to every instance
// depends on ilp_pkg
module ilp_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [ilp_pkg::OUT_W-1:0]     out_tdata,
  input logic [ilp_pkg::USER_W-1:0]    out_tuser
);
  import ilp_pkg::*;

  localparam int STEP_LSB = AXES * WORD_W;

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result dropped or changed while stalled");

  // input side only blocks while a result waits
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

  // slow request: no iterations and no saturation
  a_slow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      out_tdata[STEP_LSB +: CNT_OUT_W] == '0 && !out_tuser[1])
    else $error("too_slow result with steps or clipped set");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind intercept_lead_point_top ilp_chk u_ilp_chk (.*);

// ===== verif/tb.sv =====
// self-checking testbench for intercept_lead_point_top: directed and random aim requests,
// a bit-exact lead point predictor, random idling on both streams and a long output hold-off
// depends on ilp_pkg and the rtl of the block
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ilp_pkg::*;

  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;
  localparam int ITER_MAX = 6;
  localparam int FRAC = 16;
  localparam int PIPE_LAT = ITER_MAX * 105 + 2;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 1500;

  typedef struct {
    logic signed [31:0] shooter[3];
    logic signed [31:0] tpos[3];
    logic signed [31:0] tvel[3];
    logic [30:0]        speed;
  } aim_req_t;

  typedef struct {
    logic signed [31:0] aim[3];
    logic [2:0]         steps;
    logic               too_slow;
    logic               clipped;
  } lead_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic [USER_W-1:0] out_tuser;
  logic cfg_we = 1'b0;
  logic cfg_addr = REG_SETTLE_TOL;
  logic [TOL_W-1:0] cfg_wdata = '0;

  // predictor copy of the two registers
  logic [15:0] tol_reg = SETTLE_TOL_RST;
  logic [15:0] min_spd_reg = MIN_SPEED_RST;

  lead_t expected_leads[$];
  int errors = 0;
  int idle_pct = 6;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  int stall_cycles = 0;

  intercept_lead_point_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial forever #5 clk = ~clk;

  function automatic longint clamp32(longint v, inout bit c);
    if (v > S32_HI) begin
      c = 1'b1;
      return S32_HI;
    end
    if (v < S32_LO) begin
      c = 1'b1;
      return S32_LO;
    end
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint span3(longint a[3], longint b[3], inout bit c);
    longint unsigned sum = 0;
    longint unsigned m;
    longint unsigned d;
    longint diff;
    for (int i = 0; i < 3; i++) begin
      diff = clamp32(a[i] - b[i], c);
      m = diff < 0 ? longint'(-diff) : diff;
      sum += m * m;
    end
    d = int_sqrt(sum);
    if (d > longint'(S32_HI)) begin
      c = 1'b1;
      d = S32_HI;
    end
    return longint'(d);
  endfunction

  function automatic lead_t solve_lead(aim_req_t r);
    lead_t o;
    longint from[3], tp[3], tv[3], aim[3], nxt[3];
    longint d, tof, off;
    longint unsigned q;
    bit clip = 1'b0;
    bit ign;
    bit settled;
    int n = 0;
    for (int i = 0; i < 3; i++) begin
      from[i] = r.shooter[i];
      tp[i] = r.tpos[i];
      tv[i] = r.tvel[i];
      aim[i] = tp[i];
    end
    if (r.speed == 0 || r.speed < min_spd_reg) begin
      for (int i = 0; i < 3; i++) o.aim[i] = r.tpos[i];
      o.steps = 0;
      o.too_slow = 1'b1;
      o.clipped = 1'b0;
      return o;
    end
    for (int it = 0; it < ITER_MAX; it++) begin
      d = span3(from, aim, clip);
      q = (longint'(d) << FRAC) / longint'({33'd0, r.speed});
      if (q > longint'(S32_HI)) begin
        clip = 1'b1;
        q = S32_HI;
      end
      tof = longint'(q);
      for (int i = 0; i < 3; i++) begin
        off = clamp32((tv[i] * tof) >>> FRAC, clip);
        nxt[i] = clamp32(tp[i] + off, clip);
      end
      n++;
      ign = 1'b0;
      settled = span3(nxt, aim, ign) < longint'({48'd0, tol_reg});
      aim = nxt;
      if (settled) break;
    end
    for (int i = 0; i < 3; i++) o.aim[i] = aim[i][31:0];
    o.steps = n[2:0];
    o.too_slow = 1'b0;
    o.clipped = clip;
    return o;
  endfunction

  // every transfer on either side or on the config port resets the watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_cnt = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready = 1'b0;
    end else begin
      out_tready = quiet ? 1'b1 : ($urandom_range(99) >= 6);
    end
  end

  always @(posedge clk) begin
    lead_t exp_l;
    bit bad;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_leads.size() == 0) begin
        errors++;
        if (errors <= 10) $display("tb: lead point with nothing expected: %h", out_tdata);
      end else begin
        exp_l = expected_leads.pop_front();
        bad = out_tdata[31:0] !== exp_l.aim[0] || out_tdata[63:32] !== exp_l.aim[1]
           || out_tdata[95:64] !== exp_l.aim[2] || out_tdata[98:96] !== exp_l.steps
           || out_tuser[0] !== exp_l.too_slow || out_tuser[1] !== exp_l.clipped;
        if (bad) begin
          errors++;
          if (errors <= 10) begin
            $display("tb: mismatch exp aim %h %h %h steps %0d slow %b clip %b",
                     exp_l.aim[0], exp_l.aim[1], exp_l.aim[2], exp_l.steps,
                     exp_l.too_slow, exp_l.clipped);
            $display("tb:          got aim %h %h %h steps %0d slow %b clip %b",
                     out_tdata[31:0], out_tdata[63:32], out_tdata[95:64],
                     out_tdata[98:96], out_tuser[0], out_tuser[1]);
          end
        end
      end
    end
  end

  // starts and ends at a falling edge; valid stays high between back-to-back items
  task automatic send_req(aim_req_t r);
    while (!quiet && $urandom_range(99) < idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {1'b0, r.speed, r.tvel[2], r.tvel[1], r.tvel[0],
                r.tpos[2], r.tpos[1], r.tpos[0],
                r.shooter[2], r.shooter[1], r.shooter[0]};
    do @(posedge clk); while (!in_tready);
    expected_leads.push_back(solve_lead(r));
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (expected_leads.size() != 0) @(negedge clk);
  endtask

  task automatic set_cfg(logic [15:0] tol, logic [15:0] mins);
    drain();
    cfg_we = 1'b1;
    cfg_addr = REG_SETTLE_TOL;
    cfg_wdata = tol;
    @(negedge clk);
    cfg_addr = REG_MIN_SPEED;
    cfg_wdata = mins;
    @(negedge clk);
    cfg_we = 1'b0;
    tol_reg = tol;
    min_spd_reg = mins;
  endtask

  function automatic logic signed [31:0] rnd_word(bit full);
    if (full) return $urandom;
    return $urandom_range(32'h01FF_FFFF) - 32'sh0100_0000;
  endfunction

  function automatic aim_req_t rnd_req(bit full);
    aim_req_t r;
    for (int i = 0; i < 3; i++) begin
      r.shooter[i] = rnd_word(full);
      r.tpos[i] = rnd_word(full);
      r.tvel[i] = full ? rnd_word(1'b1) : $urandom_range(32'h0003_FFFF) - 32'sh0002_0000;
    end
    case ($urandom_range(9))
      0: r.speed = $urandom_range(200);
      1, 2: r.speed = 31'($urandom);
      default: r.speed = $urandom_range(32'h0010_0000, 32'h0200_0000);
    endcase
    return r;
  endfunction

  function automatic aim_req_t flat_req(logic signed [31:0] s, logic signed [31:0] t,
                                        logic signed [31:0] v, logic [30:0] spd);
    aim_req_t r;
    for (int i = 0; i < 3; i++) begin
      r.shooter[i] = s;
      r.tpos[i] = t;
      r.tvel[i] = v;
    end
    r.speed = spd;
    return r;
  endfunction

  task automatic test_slow_projectile();
    send_req(flat_req(32'sh0001_0000, 32'sh0050_0000, 32'sh0002_0000, 31'd0));
    send_req(flat_req(32'sh0001_0000, 32'sh0050_0000, 32'sh0002_0000, 31'd65));
    send_req(flat_req(32'sh0001_0000, 32'sh0050_0000, 32'sh0002_0000, 31'd66));
    set_cfg(16'd0, 16'd0);
    // zero speed is too slow even with no threshold
    send_req(flat_req(32'sh0001_0000, -32'sh0050_0000, 32'sh0002_0000, 31'd0));
    send_req(flat_req(32'sh0001_0000, -32'sh0050_0000, 32'sh0002_0000, 31'd1));
  endtask

  task automatic test_settling();
    set_cfg(16'hFFFF, 16'd66);
    // still target settles after one step
    send_req(flat_req(32'sh0000_0000, 32'sh0010_0000, 32'sh0000_0000, 31'h0001_0000));
    send_req(flat_req(32'sh0000_0000, 32'sh0010_0000, 32'sh0000_8000, 31'h0004_0000));
    // zero tolerance never settles: all six steps
    set_cfg(16'd0, 16'd66);
    send_req(flat_req(32'sh0000_0000, 32'sh0010_0000, 32'sh0000_8000, 31'h0004_0000));
    send_req(flat_req(-32'sh0020_0000, 32'sh0010_0000, -32'sh0003_0000, 31'h0008_0000));
  endtask

  task automatic test_extremes();
    set_cfg(16'hFFFF, 16'hFFFF);
    send_req(flat_req(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF));
    send_req(flat_req(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF));
    send_req(flat_req(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'hFFFF));
    send_req(flat_req(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 31'h1_0000));
    send_req(flat_req(32'sh0000_0000, 32'sh7FFF_FFFF, 32'sh0001_0000, 31'hFFFE));
    send_req(flat_req(-32'sd1, 32'sh0000_0000, -32'sd1, 31'h1_0000));
    set_cfg(16'd66, 16'd1);
    send_req(flat_req(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'd1));
    send_req(flat_req(32'sh0000_0000, 32'sh0000_0000, -32'sd1, 31'd1));
  endtask

  task automatic test_random(int count);
    for (int k = 0; k < count; k++) begin
      if (k % 100 == 0) set_cfg(16'($urandom_range(16'hFFFF)), 16'($urandom_range(300)));
      quiet = (k < 150);
      send_req(rnd_req($urandom_range(3) == 0));
    end
    quiet = 1'b0;
  endtask

  // receiver holds off longer than the pipeline, sender keeps offering
  task automatic test_backpressure(int count);
    set_cfg(16'($urandom_range(16'h2000)), 16'd66);
    @(negedge clk);
    hold_req = 1'b1;
    for (int k = 0; k < count; k++) send_req(rnd_req($urandom_range(4) == 0));
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_slow_projectile();
    test_settling();
    test_extremes();
    test_random(400);
    test_backpressure(400);
    drain();
    repeat (PIPE_LAT + 50) @(negedge clk);
    if (errors == 0 && expected_leads.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
